[hdl/abd_pkg.sv]
`default_nettype none

package abd_pkg;

    localparam int WORK_RAM_DEPTH = 2048;
    localparam int SAVE_RAM_DEPTH = 2048;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int FLAGS_W = 10;
    localparam int CHAN_W  = 4;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    typedef enum logic [1:0] {
        OP_MEM_READ  = 2'd0,
        OP_MEM_WRITE = 2'd1,
        OP_PORT_IN   = 2'd2,
        OP_PORT_OUT  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        EXT_NONE      = 2'd0,
        EXT_BIOS_READ = 2'd1,
        EXT_IROM_READ = 2'd2,
        EXT_VRAM_WR   = 2'd3
    } ext_kind_t;

    typedef enum logic [1:0] {
        REG_DIP_LOW   = 2'd0,
        REG_DIP_HIGH  = 2'd1,
        REG_KEY_BYTES = 2'd2,
        REG_KEY_EXTRA = 2'd3
    } reg_index_t;

    // memory map
    localparam logic [ADDR_W-1:0] WRAM_BASE  = 16'h8000;
    localparam logic [ADDR_W-1:0] SRAM_BASE  = 16'h8800;
    localparam logic [ADDR_W-1:0] BANK_BASE  = 16'h8c00;
    localparam logic [ADDR_W-1:0] BANK_TOP   = 16'h9000;
    localparam logic [ADDR_W-1:0] VRAM_TOP   = 16'h9800;
    localparam logic [ADDR_W-1:0] IROM_BASE  = 16'hc000;
    localparam logic [ADDR_W-1:0] KEY_BASE   = 16'he000;
    localparam logic [ADDR_W-1:0] BIOS_MASK  = 16'h3fff;
    localparam logic [ADDR_W-1:0] IROM_MASK  = 16'h1fff;
    localparam int                WINDOW_AW  = 10;

    localparam logic [DATA_W-1:0] KEY_IDLE   = 8'he7;
    localparam logic [DATA_W-1:0] CHAN_FILL  = 8'hff;

    // port-out numbers
    localparam logic [4:0] PORT_LAST_LOW  = 5'h06;
    localparam logic [4:0] PORT_NMI_EN    = 5'h08;
    localparam logic [4:0] PORT_WATCHDOG  = 5'h09;
    localparam logic [4:0] PORT_PPU_RESET = 5'h0a;
    localparam logic [4:0] PORT_CHAN_LO   = 5'h0b;
    localparam logic [4:0] PORT_CHAN_HI   = 5'h0e;
    localparam logic [4:0] PORT_BANK      = 5'h0f;

    localparam logic [1:0] PIN_PANEL = 2'd0;
    localparam logic [1:0] PIN_DIP_L = 2'd1;
    localparam logic [1:0] PIN_DIP_H = 2'd2;
    localparam logic [1:0] PIN_NMI   = 2'd3;

    localparam logic [3:0] FLAG_CPU_RESET = 4'd4;
    localparam logic [3:0] FLAG_NMI_EN    = 4'd7;
    localparam logic [3:0] FLAG_WATCHDOG  = 4'd8;
    localparam logic [3:0] FLAG_PPU_RESET = 4'd9;

endpackage

`default_nettype wire

[hdl/abd_ram.sv]
`default_nettype none

module abd_ram #(
    parameter int Depth = 2048,
    parameter int Width = 8,
    localparam int AddrW = $clog2(Depth)
) (
    input  wire logic             clk,
    input  wire logic             re,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] addr,
    input  wire logic [Width-1:0] wdata,
    output logic      [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[hdl/arcade_bus_decoder_with_key_prom.sv]
// channel   | handshake                      | payload
// ----------+--------------------------------+----------------------------------------------
// item      | item_valid / item_ready        | opcode address write_data panel_buttons
//           |                                | nmi_pulse
// result    | result_valid / result_ready    | read_data ext_kind ext_address ext_data
//           |                                | control_flags cpu_reset_pulse ppu_reset_pulse
// config    | apb psel/penable/pwrite, paddr | pwdata / prdata, 64 bits, regs at 8*i
//
// one item per cycle sustained while result_ready stays high; the RAM read lands with the
// first stage, and result_valid rises when that stage moves into the output register
// ram writes and all flag updates take effect at the edge that accepts the item
// rst_n resets control and flag state at once (save bank select to 1); the RAMs are not cleared
// a stalled result holds the pipe; item_ready drops only when both stages are full
// and result_ready is low
`default_nettype none

module arcade_bus_decoder_with_key_prom (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [abd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [abd_pkg::PDATA_W-1:0]   pwdata,
    output logic      [abd_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,

    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic [1:0]                    opcode,
    input  wire logic [abd_pkg::ADDR_W-1:0]    address,
    input  wire logic [abd_pkg::DATA_W-1:0]    write_data,
    input  wire logic [3:0]                    panel_buttons,
    input  wire logic                          nmi_pulse,

    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic      [abd_pkg::DATA_W-1:0]    read_data,
    output logic      [1:0]                    ext_kind,
    output logic      [abd_pkg::ADDR_W-1:0]    ext_address,
    output logic      [abd_pkg::DATA_W-1:0]    ext_data,
    output logic      [abd_pkg::FLAGS_W-1:0]   control_flags,
    output logic                               cpu_reset_pulse,
    output logic                               ppu_reset_pulse
);

    import abd_pkg::*;

    localparam int WorkAw = $clog2(WORK_RAM_DEPTH);
    localparam int SaveAw = $clog2(SAVE_RAM_DEPTH);

    typedef enum logic [1:0] {
        SRC_LOCAL = 2'd0,
        SRC_WORK  = 2'd1,
        SRC_SAVE  = 2'd2
    } src_t;

    // configuration
    logic [DATA_W-1:0]  dip_low_reg;
    logic [DATA_W-1:0]  dip_high_reg;
    logic [63:0]        key_bytes_reg;
    logic [DATA_W-1:0]  key_extra_reg;
    logic               cfg_we;
    reg_index_t         cfg_idx;

    // block state
    logic               save_bank_reg, save_bank_next;
    logic [CHAN_W-1:0]  channel_reg, channel_next;
    logic [7:0]         key_cnt_reg, key_cnt_next;
    logic               key_test_reg, key_test_next;
    logic               key_clk_reg, key_clk_next;
    logic               nmi_reg, nmi_next;
    logic [FLAGS_W-1:0] ctrl_reg, ctrl_next;

    // decode
    logic               accept;
    opcode_t            op;
    logic [DATA_W-1:0]  rd_c;
    src_t               src_c;
    ext_kind_t          kind_c;
    logic [ADDR_W-1:0]  eaddr_c;
    logic [DATA_W-1:0]  edata_c;
    logic               cpu_c, ppu_c;
    logic               work_re, work_we, save_re, save_we;
    logic [SaveAw-1:0]  save_addr_c;
    logic               nmi_eff;
    logic [4:0]         port_c;
    logic               port_bit;
    logic               flag_hit;
    logic [3:0]         flag_idx;
    logic               flag_old;
    logic [1:0]         chan_idx;
    logic [DATA_W-1:0]  key_c;

    // pipe
    logic               p1_valid_reg;
    logic               p1_adv;
    logic [DATA_W-1:0]  p1_rd_reg;
    src_t               p1_src_reg;
    ext_kind_t          p1_kind_reg;
    logic [ADDR_W-1:0]  p1_eaddr_reg;
    logic [DATA_W-1:0]  p1_edata_reg;
    logic [FLAGS_W-1:0] p1_flags_reg;
    logic               p1_cpu_reg, p1_ppu_reg;
    logic [DATA_W-1:0]  work_q, save_q;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_rd_reg;
    ext_kind_t          out_kind_reg;
    logic [ADDR_W-1:0]  out_eaddr_reg;
    logic [DATA_W-1:0]  out_edata_reg;
    logic [FLAGS_W-1:0] out_flags_reg;
    logic               out_cpu_reg, out_ppu_reg;

    function automatic logic [DATA_W-1:0] key_value(
        input logic [7:0]        cnt,
        input logic              test,
        input logic [63:0]       bytes,
        input logic [DATA_W-1:0] extra
    );
        logic [DATA_W-1:0] sel;
        logic [DATA_W-1:0] v;
        v = KEY_IDLE;
        if (!test || !cnt[6])
        begin
            sel = bytes[{cnt[5:3], 3'b000} +: DATA_W];
        end
        else
        begin
            sel = cnt[4] ? '0 : extra;
        end
        v[3] = ~sel[cnt[2:0]];
        v[4] = v[4] | ~cnt[5];
        return v;
    endfunction

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_index_t'(paddr[PADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip_low_reg   <= '0;
            dip_high_reg  <= '0;
            key_bytes_reg <= '0;
            key_extra_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_DIP_LOW:   dip_low_reg   <= pwdata[DATA_W-1:0];
                REG_DIP_HIGH:  dip_high_reg  <= pwdata[DATA_W-1:0];
                REG_KEY_BYTES: key_bytes_reg <= pwdata;
                REG_KEY_EXTRA: key_extra_reg <= pwdata[DATA_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_DIP_LOW:   prdata = {{(PDATA_W-DATA_W){1'b0}}, dip_low_reg};
            REG_DIP_HIGH:  prdata = {{(PDATA_W-DATA_W){1'b0}}, dip_high_reg};
            REG_KEY_BYTES: prdata = key_bytes_reg;
            REG_KEY_EXTRA: prdata = {{(PDATA_W-DATA_W){1'b0}}, key_extra_reg};
        endcase
    end

    // ---------------- handshake ----------------
    assign p1_adv     = p1_valid_reg & (~out_valid_reg | result_ready);
    assign item_ready = ~p1_valid_reg | ~out_valid_reg | result_ready;
    assign accept     = item_valid & item_ready;
    assign op         = opcode_t'(opcode);

    // ---------------- decode ----------------
    assign key_c    = key_value(key_cnt_reg, key_test_reg, key_bytes_reg, key_extra_reg);
    assign port_c   = address[4:0];
    assign port_bit = write_data[0];
    assign nmi_eff  = nmi_reg | nmi_pulse;
    assign chan_idx = 2'(port_c - PORT_CHAN_LO);

    always_comb
    begin
        if (address >= BANK_BASE)
        begin
            save_addr_c = SaveAw'({save_bank_reg, address[WINDOW_AW-1:0]});
        end
        else
        begin
            save_addr_c = SaveAw'(address[WINDOW_AW-1:0]);
        end
    end

    always_comb
    begin
        rd_c           = '0;
        src_c          = SRC_LOCAL;
        kind_c         = EXT_NONE;
        eaddr_c        = '0;
        edata_c        = '0;
        cpu_c          = 1'b0;
        ppu_c          = 1'b0;
        work_re        = 1'b0;
        work_we        = 1'b0;
        save_re        = 1'b0;
        save_we        = 1'b0;
        flag_hit       = 1'b0;
        flag_idx       = '0;
        flag_old       = 1'b0;
        save_bank_next = save_bank_reg;
        channel_next   = channel_reg;
        key_cnt_next   = key_cnt_reg;
        key_test_next  = key_test_reg;
        key_clk_next   = key_clk_reg;
        nmi_next       = nmi_eff;
        ctrl_next      = ctrl_reg;

        unique case (op)
            OP_MEM_READ:
            begin
                priority if (address < WRAM_BASE)
                begin
                    kind_c  = EXT_BIOS_READ;
                    eaddr_c = address & BIOS_MASK;
                end
                else if (address < SRAM_BASE)
                begin
                    src_c   = SRC_WORK;
                    work_re = 1'b1;
                end
                else if (address < BANK_TOP)
                begin
                    src_c   = SRC_SAVE;
                    save_re = 1'b1;
                end
                else if (address < IROM_BASE)
                begin
                    rd_c = '0;
                end
                else if (channel_reg != '0)
                begin
                    rd_c = CHAN_FILL;
                end
                else if (address < KEY_BASE)
                begin
                    kind_c  = EXT_IROM_READ;
                    eaddr_c = address & IROM_MASK;
                end
                else
                begin
                    rd_c = key_c;
                end
            end
            OP_MEM_WRITE:
            begin
                priority if (address < WRAM_BASE)
                begin
                    work_we = 1'b0;
                end
                else if (address < SRAM_BASE)
                begin
                    work_we = 1'b1;
                end
                else if (address < BANK_TOP)
                begin
                    save_we = 1'b1;
                end
                else if (address < VRAM_TOP)
                begin
                    kind_c  = EXT_VRAM_WR;
                    eaddr_c = address;
                    edata_c = write_data;
                end
                else if (address >= KEY_BASE)
                begin
                    key_test_next = write_data[4];
                    key_clk_next  = write_data[3];
                    // falling clock edge steps the counter, low bit 0 clears it
                    if (key_clk_reg && !write_data[3])
                    begin
                        key_cnt_next = key_cnt_reg + 8'd1;
                    end
                    if (!write_data[0])
                    begin
                        key_cnt_next = '0;
                    end
                end
                else
                begin
                    // writes between video RAM and the key PROM are dropped
                    work_we = 1'b0;
                end
            end
            OP_PORT_IN:
            begin
                unique case (address[1:0])
                    PIN_PANEL: rd_c = {1'b0, panel_buttons[3], 2'b00, ~nmi_eff,
                                       panel_buttons[2:0]};
                    PIN_DIP_L: rd_c = dip_low_reg;
                    PIN_DIP_H: rd_c = dip_high_reg;
                    PIN_NMI:   nmi_next = 1'b0;
                endcase
            end
            OP_PORT_OUT:
            begin
                priority if (port_c <= PORT_LAST_LOW)
                begin
                    flag_hit = 1'b1;
                    flag_idx = port_c[3:0];
                end
                else if (port_c == PORT_NMI_EN)
                begin
                    flag_hit = 1'b1;
                    flag_idx = FLAG_NMI_EN;
                end
                else if (port_c == PORT_WATCHDOG)
                begin
                    flag_hit = 1'b1;
                    flag_idx = FLAG_WATCHDOG;
                end
                else if (port_c == PORT_PPU_RESET)
                begin
                    flag_hit = 1'b1;
                    flag_idx = FLAG_PPU_RESET;
                end
                else if (port_c >= PORT_CHAN_LO && port_c <= PORT_CHAN_HI)
                begin
                    channel_next[chan_idx] = port_bit;
                end
                else if (port_c == PORT_BANK)
                begin
                    save_bank_next = port_bit;
                end
                else
                begin
                    // remaining ports do nothing
                    flag_hit = 1'b0;
                end
                if (flag_hit)
                begin
                    flag_old            = ctrl_reg[flag_idx];
                    ctrl_next[flag_idx] = port_bit;
                    cpu_c = (flag_idx == FLAG_CPU_RESET) & ~flag_old & port_bit;
                    ppu_c = (flag_idx == FLAG_PPU_RESET) & ~flag_old & port_bit;
                end
            end
        endcase
    end

    // ---------------- state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            save_bank_reg <= 1'b1;
            channel_reg   <= '0;
            key_cnt_reg   <= '0;
            key_test_reg  <= 1'b0;
            key_clk_reg   <= 1'b0;
            nmi_reg       <= 1'b0;
            ctrl_reg      <= '0;
        end
        else if (accept)
        begin
            save_bank_reg <= save_bank_next;
            channel_reg   <= channel_next;
            key_cnt_reg   <= key_cnt_next;
            key_test_reg  <= key_test_next;
            key_clk_reg   <= key_clk_next;
            nmi_reg       <= nmi_next;
            ctrl_reg      <= ctrl_next;
        end
    end

    // ---------------- memories ----------------
    abd_ram #(
        .Depth (WORK_RAM_DEPTH),
        .Width (DATA_W)
    ) u_work_ram (
        .clk   (clk),
        .re    (accept & work_re),
        .we    (accept & work_we),
        .addr  (address[WorkAw-1:0]),
        .wdata (write_data),
        .rdata (work_q)
    );

    abd_ram #(
        .Depth (SAVE_RAM_DEPTH),
        .Width (DATA_W)
    ) u_save_ram (
        .clk   (clk),
        .re    (accept & save_re),
        .we    (accept & save_we),
        .addr  (save_addr_c),
        .wdata (write_data),
        .rdata (save_q)
    );

    // ---------------- pipe ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_rd_reg    <= rd_c;
            p1_src_reg   <= src_c;
            p1_kind_reg  <= kind_c;
            p1_eaddr_reg <= eaddr_c;
            p1_edata_reg <= edata_c;
            p1_flags_reg <= ctrl_next;
            p1_cpu_reg   <= cpu_c;
            p1_ppu_reg   <= ppu_c;
        end
        if (p1_adv)
        begin
            unique case (p1_src_reg)
                SRC_WORK: out_rd_reg <= work_q;
                SRC_SAVE: out_rd_reg <= save_q;
                default:  out_rd_reg <= p1_rd_reg;
            endcase
            out_kind_reg  <= p1_kind_reg;
            out_eaddr_reg <= p1_eaddr_reg;
            out_edata_reg <= p1_edata_reg;
            out_flags_reg <= p1_flags_reg;
            out_cpu_reg   <= p1_cpu_reg;
            out_ppu_reg   <= p1_ppu_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign read_data       = out_rd_reg;
    assign ext_kind        = out_kind_reg;
    assign ext_address     = out_eaddr_reg;
    assign ext_data        = out_edata_reg;
    assign control_flags   = out_flags_reg;
    assign cpu_reset_pulse = out_cpu_reg;
    assign ppu_reset_pulse = out_ppu_reg;

endmodule

`default_nettype wire

[hdl/abd_checker.sv]
`default_nettype none

module abd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [abd_pkg::DATA_W-1:0]    read_data,
    input wire logic [1:0]                    ext_kind,
    input wire logic [abd_pkg::ADDR_W-1:0]    ext_address,
    input wire logic [abd_pkg::DATA_W-1:0]    ext_data,
    input wire logic [abd_pkg::FLAGS_W-1:0]   control_flags,
    input wire logic                          cpu_reset_pulse,
    input wire logic                          ppu_reset_pulse
);

    import abd_pkg::*;

    // a stalled item keeps its read data, ext kind, ext address and control flags
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(read_data)
            && $stable(ext_kind) && $stable(ext_address) && $stable(control_flags))
        else $error("result item changed while stalled");

    // no external request means no address or data on the side bus
    a_ext_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ext_kind == EXT_NONE |-> ext_address == '0 && ext_data == '0)
        else $error("external fields set without a request");

    a_cpu_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && cpu_reset_pulse |-> control_flags[FLAG_CPU_RESET])
        else $error("cpu reset pulse with reset line low");

    a_ppu_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ppu_reset_pulse |-> control_flags[FLAG_PPU_RESET]
            && !cpu_reset_pulse)
        else $error("video reset pulse inconsistent with flags");

endmodule

bind arcade_bus_decoder_with_key_prom abd_checker u_abd_checker (.*);

`default_nettype wire

[dv/arcade_bus_decoder_with_key_prom_tb.sv]
`default_nettype none

module arcade_bus_decoder_with_key_prom_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import abd_pkg::*;

    localparam int HOLD_CYCLES = 120;
    localparam int RANDOM_ITEMS = 780;

    typedef struct packed {
        logic [DATA_W-1:0]  rd;
        ext_kind_t          kind;
        logic [ADDR_W-1:0]  eaddr;
        logic [DATA_W-1:0]  edata;
        logic [FLAGS_W-1:0] flags;
        logic               cpu_pulse;
        logic               ppu_pulse;
    } bus_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic                item_valid;
    logic                item_ready;
    logic [1:0]          opcode;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   write_data;
    logic [3:0]          panel_buttons;
    logic                nmi_pulse;

    logic                result_valid;
    logic                result_ready;
    logic [DATA_W-1:0]   read_data;
    logic [1:0]          ext_kind;
    logic [ADDR_W-1:0]   ext_address;
    logic [DATA_W-1:0]   ext_data;
    logic [FLAGS_W-1:0]  control_flags;
    logic                cpu_reset_pulse;
    logic                ppu_reset_pulse;

    arcade_bus_decoder_with_key_prom u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .opcode          (opcode),
        .address         (address),
        .write_data      (write_data),
        .panel_buttons   (panel_buttons),
        .nmi_pulse       (nmi_pulse),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .read_data       (read_data),
        .ext_kind        (ext_kind),
        .ext_address     (ext_address),
        .ext_data        (ext_data),
        .control_flags   (control_flags),
        .cpu_reset_pulse (cpu_reset_pulse),
        .ppu_reset_pulse (ppu_reset_pulse)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the decoder state
    logic [DATA_W-1:0]  work_mem [WORK_RAM_DEPTH];
    logic [DATA_W-1:0]  save_mem [SAVE_RAM_DEPTH];
    bit                 work_set [WORK_RAM_DEPTH];
    bit                 save_set [SAVE_RAM_DEPTH];
    int                 work_list [$];
    int                 save_list [$];
    logic               bank_sel;
    logic [CHAN_W-1:0]  channel;
    logic [7:0]         key_count;
    logic               key_test;
    logic               key_clk_lvl;
    logic               nmi_latched;
    logic [FLAGS_W-1:0] ctrl_flags;

    logic [7:0]         cfg_dip_low;
    logic [7:0]         cfg_dip_high;
    logic [63:0]        cfg_key_bytes;
    logic [7:0]         cfg_key_extra;

    bus_result_t        pending [$];

    int  mismatches  = 0;
    int  items_sent  = 0;
    int  key_reads   = 0;
    int  ram_reads   = 0;
    int  pulses      = 0;
    int  full_cycles = 0;
    int  burst_left  = 0;
    bit  gaps_off    = 0;
    bit  hold_request = 0;

    function automatic logic [7:0] key_prom_byte();
        logic [7:0] sel;
        logic [7:0] v;
        v = KEY_IDLE;
        if (!key_test || !key_count[6])
            sel = cfg_key_bytes[key_count[5:3]*8 +: 8];
        else
            sel = key_count[4] ? 8'h00 : cfg_key_extra;
        if (!sel[key_count[2:0]])
            v[3] = 1'b1;
        if (!key_count[5])
            v[4] = 1'b1;
        return v;
    endfunction

    function automatic void store_work(logic [10:0] idx, logic [7:0] d);
        work_mem[idx] = d;
        if (!work_set[idx])
        begin
            work_set[idx] = 1'b1;
            work_list.push_back(int'(idx));
        end
    endfunction

    function automatic void store_save(logic [10:0] idx, logic [7:0] d);
        save_mem[idx] = d;
        if (!save_set[idx])
        begin
            save_set[idx] = 1'b1;
            save_list.push_back(int'(idx));
        end
    endfunction

    function automatic bus_result_t predict_access(opcode_t op, logic [15:0] a, logic [7:0] d,
                                                   logic [3:0] panel, logic nmi);
        bus_result_t r;
        logic [10:0] bank_idx;
        logic [4:0]  port;
        int          flag;
        logic        old;
        r = '0;
        bank_idx = {bank_sel, a[9:0]};
        if (nmi)
            nmi_latched = 1'b1;
        case (op)
            OP_MEM_READ:
            begin
                if (a < WRAM_BASE)
                begin
                    r.kind  = EXT_BIOS_READ;
                    r.eaddr = a & BIOS_MASK;
                end
                else if (a < SRAM_BASE)
                begin
                    r.rd = work_mem[a[10:0]];
                    ram_reads++;
                end
                else if (a < BANK_BASE)
                begin
                    r.rd = save_mem[{1'b0, a[9:0]}];
                    ram_reads++;
                end
                else if (a < BANK_TOP)
                begin
                    r.rd = save_mem[bank_idx];
                    ram_reads++;
                end
                else if (a < IROM_BASE)
                    r.rd = '0;
                else if (channel != '0)
                    r.rd = CHAN_FILL;
                else if (a < KEY_BASE)
                begin
                    r.kind  = EXT_IROM_READ;
                    r.eaddr = a & IROM_MASK;
                end
                else
                begin
                    r.rd = key_prom_byte();
                    key_reads++;
                end
            end
            OP_MEM_WRITE:
            begin
                if (a < WRAM_BASE)
                    ;
                else if (a < SRAM_BASE)
                    store_work(a[10:0], d);
                else if (a < BANK_BASE)
                    store_save({1'b0, a[9:0]}, d);
                else if (a < BANK_TOP)
                    store_save(bank_idx, d);
                else if (a < VRAM_TOP)
                begin
                    r.kind  = EXT_VRAM_WR;
                    r.eaddr = a;
                    r.edata = d;
                end
                else if (a < KEY_BASE)
                    ;
                else
                begin
                    key_test = d[4];
                    // falling edge of the key clock steps the counter
                    if (key_clk_lvl && !d[3])
                        key_count = key_count + 8'd1;
                    key_clk_lvl = d[3];
                    if (!d[0])
                        key_count = '0;
                end
            end
            OP_PORT_IN:
            begin
                case (a[1:0])
                    PIN_PANEL: r.rd = {1'b0, panel[3], 2'b00, ~nmi_latched, panel[2:0]};
                    PIN_DIP_L: r.rd = cfg_dip_low;
                    PIN_DIP_H: r.rd = cfg_dip_high;
                    PIN_NMI:
                    begin
                        nmi_latched = 1'b0;
                        r.rd = '0;
                    end
                endcase
            end
            OP_PORT_OUT:
            begin
                port = a[4:0];
                flag = -1;
                if (port <= PORT_LAST_LOW)
                    flag = int'(port);
                else if (port == PORT_NMI_EN)
                    flag = int'(FLAG_NMI_EN);
                else if (port == PORT_WATCHDOG)
                    flag = int'(FLAG_WATCHDOG);
                else if (port == PORT_PPU_RESET)
                    flag = int'(FLAG_PPU_RESET);
                else if (port >= PORT_CHAN_LO && port <= PORT_CHAN_HI)
                    channel[port - PORT_CHAN_LO] = d[0];
                else if (port == PORT_BANK)
                    bank_sel = d[0];
                if (flag >= 0)
                begin
                    old = ctrl_flags[flag];
                    if (flag == int'(FLAG_CPU_RESET) && !old && d[0])
                        r.cpu_pulse = 1'b1;
                    if (flag == int'(FLAG_PPU_RESET) && !old && d[0])
                        r.ppu_pulse = 1'b1;
                    ctrl_flags[flag] = d[0];
                end
            end
        endcase
        r.flags = ctrl_flags;
        if (r.cpu_pulse || r.ppu_pulse)
            pulses++;
        return r;
    endfunction

    function automatic bit read_is_defined(logic [15:0] a);
        if (a >= WRAM_BASE && a < SRAM_BASE)
            return work_set[a[10:0]];
        if (a >= SRAM_BASE && a < BANK_BASE)
            return save_set[{1'b0, a[9:0]}];
        if (a >= BANK_BASE && a < BANK_TOP)
            return save_set[{bank_sel, a[9:0]}];
        return 1'b1;
    endfunction

    task automatic pause(int n);
        repeat (n)
        begin
            @(negedge clk);
            item_valid = 1'b0;
        end
    endtask

    task automatic send_item(opcode_t op, logic [15:0] a, logic [7:0] d, logic [3:0] panel,
                             logic nmi);
        @(negedge clk);
        item_valid    = 1'b1;
        opcode        = op;
        address       = a;
        write_data    = d;
        panel_buttons = panel;
        nmi_pulse     = nmi;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending.push_back(predict_access(op, a, d, panel, nmi));
        items_sent++;
    endtask

    task automatic issue_full(opcode_t op, logic [15:0] a, logic [7:0] d, logic [3:0] panel,
                              logic nmi);
        // never read a RAM entry that was not written yet
        if (op == OP_MEM_READ && !read_is_defined(a))
            op = OP_MEM_WRITE;
        if (burst_left == 0)
        begin
            if (!gaps_off && $urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_item(op, a, d, panel, nmi);
    endtask

    task automatic issue(opcode_t op, logic [15:0] a, logic [7:0] d);
        issue_full(op, a, d, 4'($urandom), $urandom_range(0, 9) == 0);
    endtask

    task automatic settle();
        pause(1);
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(reg_index_t idx, logic [63:0] v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_DIP_LOW:   cfg_dip_low   = v[7:0];
            REG_DIP_HIGH:  cfg_dip_high  = v[7:0];
            REG_KEY_BYTES: cfg_key_bytes = v;
            REG_KEY_EXTRA: cfg_key_extra = v[7:0];
        endcase
    endtask

    task automatic configure(logic [7:0] dl, logic [7:0] dh, logic [63:0] kb, logic [7:0] ke);
        settle();
        reg_write(REG_DIP_LOW, 64'(dl));
        reg_write(REG_DIP_HIGH, 64'(dh));
        reg_write(REG_KEY_BYTES, kb);
        reg_write(REG_KEY_EXTRA, 64'(ke));
    endtask

    function automatic logic [15:0] key_addr();
        return KEY_BASE | 16'($urandom_range(0, 16'h1fff));
    endfunction

    task automatic rand_ram_write();
        logic [15:0] a;
        case ($urandom_range(0, 3))
            0: a = WRAM_BASE | 16'($urandom_range(0, 16'h07ff));
            1: a = SRAM_BASE | 16'($urandom_range(0, 16'h03ff));
            2: a = BANK_BASE | 16'($urandom_range(0, 16'h03ff));
            default: a = BANK_TOP | 16'($urandom_range(0, 16'h07ff));
        endcase
        issue(OP_MEM_WRITE, a, 8'($urandom));
    endtask

    task automatic rand_ram_read();
        int          idx;
        logic [15:0] a;
        bit          found;
        found = 1'b0;
        case ($urandom_range(0, 2))
            0:
                if (work_list.size() > 0)
                begin
                    idx   = work_list[$urandom_range(0, work_list.size() - 1)];
                    a     = WRAM_BASE | 16'(idx);
                    found = 1'b1;
                end
            1:
                repeat (8)
                    if (!found && save_list.size() > 0)
                    begin
                        idx = save_list[$urandom_range(0, save_list.size() - 1)];
                        if (idx < 1024)
                        begin
                            a     = SRAM_BASE | 16'(idx);
                            found = 1'b1;
                        end
                    end
            default:
                repeat (8)
                    if (!found && save_list.size() > 0)
                    begin
                        idx = save_list[$urandom_range(0, save_list.size() - 1)];
                        if (idx[10] == bank_sel)
                        begin
                            a     = BANK_BASE | 16'(idx & 16'h03ff);
                            found = 1'b1;
                        end
                    end
        endcase
        if (found)
            issue(OP_MEM_READ, a, 8'($urandom));
        else
            rand_ram_write();
    endtask

    task automatic rand_other_read();
        case ($urandom_range(0, 2))
            0: issue(OP_MEM_READ, 16'($urandom_range(0, 16'h7fff)), 8'($urandom));
            1: issue(OP_MEM_READ, 16'($urandom_range(16'h9000, 16'hbfff)), 8'($urandom));
            default: issue(OP_MEM_READ, 16'($urandom_range(16'hc000, 16'hffff)), 8'($urandom));
        endcase
    endtask

    task automatic noise_item();
        issue(opcode_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
    endtask

    // clear the key counter, then step it, with reads after some or all steps
    task automatic key_walk(int steps, bit test);
        logic [7:0] d;
        bit         read_all;
        read_all = (steps <= 24);
        for (int i = 0; i < CHAN_W; i++)
            if (channel[i])
                issue(OP_PORT_OUT, 16'(PORT_CHAN_LO) + 16'(i), 8'($urandom) & 8'hfe);
        d = 8'($urandom);
        d[4] = test;
        d[3] = 1'b0;
        d[0] = 1'b0;
        issue(OP_MEM_WRITE, key_addr(), d);
        issue(OP_MEM_READ, key_addr(), 8'($urandom));
        repeat (steps)
        begin
            d = 8'($urandom);
            d[4] = test ^ ($urandom_range(0, 6) == 0);
            d[3] = 1'b1;
            d[0] = 1'b1;
            issue(OP_MEM_WRITE, key_addr(), d);
            d = 8'($urandom);
            d[4] = test ^ ($urandom_range(0, 6) == 0);
            d[3] = 1'b0;
            d[0] = 1'b1;
            issue(OP_MEM_WRITE, key_addr(), d);
            if (read_all || $urandom_range(0, 9) < 4)
                issue(OP_MEM_READ, key_addr(), 8'($urandom));
        end
    endtask

    task automatic port_burst();
        logic [15:0] p;
        repeat ($urandom_range(2, 8))
        begin
            case ($urandom_range(0, 4))
                0: issue(OP_PORT_IN, 16'($urandom), 8'($urandom));
                1: issue(OP_PORT_OUT, 16'($urandom), 8'($urandom));
                2:
                begin
                    p = $urandom_range(0, 1) ? 16'(PORT_PPU_RESET) : 16'(FLAG_CPU_RESET);
                    p[15:5] = 11'($urandom);
                    issue(OP_PORT_OUT, p, 8'($urandom) & 8'hfe);
                    issue(OP_PORT_OUT, p, 8'($urandom) | 8'h01);
                end
                3: issue(OP_PORT_OUT, 16'(PORT_CHAN_LO) + 16'($urandom_range(0, 3)),
                         8'($urandom_range(0, 3) == 0));
                default: issue(OP_PORT_OUT, 16'(PORT_BANK), 8'($urandom));
            endcase
        end
    endtask

    task automatic mem_burst();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) rand_ram_write();
        repeat (n) rand_ram_read();
        if ($urandom_range(0, 1))
            rand_other_read();
    endtask

    task automatic test_directed();
        configure(8'h00, 8'hff, 64'h0123_4567_89ab_cdef, 8'h5a);
        issue(OP_MEM_READ, 16'h0000, 8'h00);
        issue(OP_MEM_READ, 16'h7fff, 8'hff);
        issue(OP_MEM_WRITE, 16'h8000, 8'hff);
        issue(OP_MEM_WRITE, 16'h87ff, 8'h00);
        issue(OP_MEM_READ, 16'h8000, 8'h00);
        issue(OP_MEM_READ, 16'h87ff, 8'h00);
        issue(OP_MEM_WRITE, 16'h8800, 8'ha5);
        issue(OP_MEM_WRITE, 16'h8c00, 8'h3c);
        issue(OP_MEM_READ, 16'h8c00, 8'h00);
        issue(OP_MEM_WRITE, 16'h97ff, 8'h81);
        issue(OP_MEM_READ, 16'h9400, 8'h00);
        issue(OP_MEM_READ, 16'hbfff, 8'h00);
        issue(OP_MEM_WRITE, 16'h7fff, 8'h11);
        issue(OP_MEM_WRITE, 16'hdfff, 8'h22);
        issue(OP_MEM_READ, 16'hc000, 8'h00);
        issue(OP_MEM_READ, 16'he000, 8'h00);
        issue(OP_MEM_WRITE, 16'hffff, 8'h19);
        issue_full(OP_PORT_IN, 16'h0000, 8'h00, 4'hf, 1'b1);
        issue_full(OP_PORT_IN, 16'hffff, 8'h00, 4'h0, 1'b0);
        issue_full(OP_PORT_IN, 16'h0000, 8'h00, 4'h0, 1'b0);
        issue(OP_PORT_IN, 16'h0001, 8'h00);
        issue(OP_PORT_IN, 16'h0002, 8'h00);
        issue(OP_PORT_OUT, 16'(FLAG_CPU_RESET), 8'h01);
        issue(OP_PORT_OUT, 16'(PORT_PPU_RESET), 8'hff);
        issue(OP_PORT_OUT, 16'h0007, 8'h01);
        issue(OP_PORT_OUT, 16'hffff, 8'h01);
        issue(OP_PORT_OUT, 16'(PORT_CHAN_LO), 8'h01);
        issue(OP_MEM_READ, 16'hffff, 8'h00);
        issue(OP_PORT_OUT, 16'(PORT_CHAN_LO), 8'hfe);
        issue(OP_PORT_OUT, 16'(PORT_BANK), 8'h00);
        issue(OP_MEM_READ, 16'h8c00, 8'h00);
    endtask

    task automatic test_config_settings();
        for (int s = 0; s < 4; s++)
        begin
            case (s)
                0: configure(8'h00, 8'h00, 64'h0, 8'h00);
                1: configure(8'hff, 8'hff, '1, 8'hff);
                2: configure(8'ha5, 8'h5a, 64'haaaa_5555_f0f0_0f0f, 8'h55);
                default: configure(8'($urandom), 8'($urandom), {$urandom, $urandom},
                                   8'($urandom));
            endcase
            issue(OP_PORT_IN, (16'($urandom) | 16'h0001) & 16'hfffd, 8'($urandom));
            issue(OP_PORT_IN, (16'($urandom) & 16'hfffc) | 16'h0002, 8'($urandom));
            key_walk($urandom_range(8, 24), $urandom_range(0, 1));
        end
    endtask

    task automatic test_key_prom_long();
        configure(8'($urandom), 8'($urandom), {$urandom, $urandom}, 8'($urandom) | 8'h01);
        // long enough for the counter to wrap
        key_walk(258, 1'b1);
        key_walk(70, 1'b0);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        gaps_off = 1'b1;
        repeat (48) noise_item();
        gaps_off = 1'b0;
    endtask

    task automatic test_random_traffic();
        int target;
        for (int c = 0; c < 4; c++)
        begin
            if (c == 3)
                configure(8'hff, 8'h00, '1, 8'h00);
            else
                configure(8'($urandom), 8'($urandom), {$urandom, $urandom}, 8'($urandom));
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target)
            begin
                case ($urandom_range(0, 99)) inside
                    [0:14]:  key_walk($urandom_range(2, 12), $urandom_range(0, 1));
                    [15:44]: mem_burst();
                    [45:64]: port_burst();
                    [65:74]:
                    begin
                        issue(OP_PORT_OUT, 16'(PORT_BANK), 8'($urandom));
                        rand_ram_write();
                        rand_ram_read();
                    end
                    default: noise_item();
                endcase
            end
        end
    endtask

    // result side: stall pattern plus one long hold-off on request
    initial
    begin
        int stall_pct;
        int stall_run;
        int held;
        stall_pct = 0;
        stall_run = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready = 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held++;
                end
            end
            if (stall_run == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2:    stall_pct = 15;
                    3:    stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                stall_run = $urandom_range(16, 96);
            end
            stall_run--;
            result_ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void report(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
            report($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endfunction

    always @(posedge clk)
    begin
        bus_result_t want;
        if (rst_n)
        begin
            if (item_valid && !item_ready)
                full_cycles++;
            if (result_valid && result_ready)
            begin
                if (pending.size() == 0)
                    report("result with no item waiting");
                else
                begin
                    want = pending.pop_front();
                    check_field("read_data", 16'(want.rd), 16'(read_data));
                    check_field("ext_kind", 16'(want.kind), 16'(ext_kind));
                    check_field("ext_address", want.eaddr, ext_address);
                    check_field("ext_data", 16'(want.edata), 16'(ext_data));
                    check_field("control_flags", 16'(want.flags), 16'(control_flags));
                    check_field("cpu_reset_pulse", 16'(want.cpu_pulse), 16'(cpu_reset_pulse));
                    check_field("ppu_reset_pulse", 16'(want.ppu_pulse), 16'(ppu_reset_pulse));
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL arcade_bus_decoder_with_key_prom");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_valid    = 1'b0;
        opcode        = OP_MEM_READ;
        address       = '0;
        write_data    = '0;
        panel_buttons = '0;
        nmi_pulse     = 1'b0;
        result_ready  = 1'b0;

        bank_sel      = 1'b1;
        channel       = '0;
        key_count     = '0;
        key_test      = 1'b0;
        key_clk_lvl   = 1'b0;
        nmi_latched   = 1'b0;
        ctrl_flags    = '0;
        cfg_dip_low   = '0;
        cfg_dip_high  = '0;
        cfg_key_bytes = '0;
        cfg_key_extra = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_settings();
        test_key_prom_long();
        test_backpressure();
        test_random_traffic();

        settle();
        repeat (10) @(posedge clk);
        $display("ran %0d bus accesses: %0d key PROM reads, %0d RAM reads, %0d reset pulses",
                 items_sent, key_reads, ram_reads, pulses);
        $display("input held off on %0d cycles; %0d field mismatches", full_cycles, mismatches);
        if (mismatches == 0 && pending.size() == 0)
            $display("PASS arcade_bus_decoder_with_key_prom");
        else
            $display("FAIL arcade_bus_decoder_with_key_prom");
        $finish;
    end

endmodule

`default_nettype wire
